// ===== rtl/core/tmrt_pkg.sv =====
// Shared types and codes for the timed message release table.
`default_nettype none

package tmrt_pkg;

    // Input operation codes
    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // Result kind codes
    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_POLL   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the accepted input item
        logic idx_clr;      // restart the slot scan at slot zero
        logic idx_inc;      // advance the scan to the next slot
        logic write_slot;   // store the submitted message at the scan slot
        logic clear_slot;   // free the scan slot
        logic hold_load;    // keep the released payload of the scan slot
        logic held_clr;     // drop the kept payload
        logic emit_sub;     // load a submit answer into the output register
        logic sub_acc;      // accepted flag of that answer
        logic emit_mid;     // load the kept payload as a non-final result
        logic emit_final;   // load the final poll result
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_free;    // scan slot holds no message
        logic slot_hit;     // scan slot holds a message that is due
        logic idx_last;     // scan is at the highest slot
        logic held_valid;   // a released payload waits to be sent
        logic out_free;     // output register can take a result this cycle
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmrt_ctrl.sv =====
// Controller state machine sequencing the slot scans of the release table.
`default_nettype none

module tmrt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          op,
    input  tmrt_pkg::sts_t     sts,
    output tmrt_pkg::cmd_t     cmd
);
    import tmrt_pkg::*;

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_SUB_SCAN  = 2'd1;
    localparam logic [1:0] ST_POLL_SCAN = 2'd2;
    localparam logic [1:0] ST_POLL_END  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Hold the scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode the next state and the datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = (op == OP_POLL) ? ST_POLL_SCAN : ST_SUB_SCAN;
                end
            end
            ST_SUB_SCAN:
            begin
                // take the first free slot, or reject after the last one
                if (sts.slot_free)
                begin
                    if (sts.out_free)
                    begin
                        cmd.write_slot = 1'b1;
                        cmd.emit_sub   = 1'b1;
                        cmd.sub_acc    = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (sts.idx_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_sub = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_POLL_SCAN:
            begin
                // stall only when a second release finds the output busy
                if (!(sts.slot_hit && sts.held_valid && !sts.out_free))
                begin
                    if (sts.slot_hit)
                    begin
                        cmd.clear_slot = 1'b1;
                        cmd.hold_load  = 1'b1;
                        cmd.emit_mid   = sts.held_valid;
                    end
                    if (sts.idx_last)
                    begin
                        state_next = ST_POLL_END;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_POLL_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    cmd.held_clr   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tmrt_datapath.sv =====
// Slot storage, scan index, held release and output register of the table.
`default_nettype none

module tmrt_datapath #(
    parameter int SLOTS        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  tmrt_pkg::cmd_t     cmd,
    output tmrt_pkg::sts_t     sts,
    input  wire logic          op,
    input  wire logic [31:0]   payload,
    input  wire logic [31:0]   due_time,
    input  wire logic [31:0]   now_time,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               kind,
    output logic               accepted,
    output logic               has_message,
    output logic [31:0]        released_payload,
    output logic               last
);
    import tmrt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // captured input item
    logic                    op_reg;
    logic [31:0]             pay_reg;
    logic [31:0]             due_reg;
    logic [31:0]             now_reg;

    // slot table
    logic [SLOTS-1:0]        valid_reg;
    logic [31:0]             mem_due [SLOTS];
    logic [PAYLOAD_BITS-1:0] mem_pay [SLOTS];
    logic [31:0]             rd_due_reg;
    logic [PAYLOAD_BITS-1:0] rd_pay_reg;

    // scan index
    logic [IW-1:0]           idx_reg;
    logic [IW-1:0]           idx_next;

    // kept release and output register
    logic                    held_valid_reg;
    logic [31:0]             held_pay_reg;
    logic                    out_valid_reg;
    logic                    kind_reg;
    logic                    acc_reg;
    logic                    has_reg;
    logic [31:0]             pay_out_reg;
    logic                    last_reg;

    logic [63:0]             wr_wide;
    logic [63:0]             rd_wide;
    logic [31:0]             rd_pay32;
    logic                    load;

    assign wr_wide  = {32'd0, pay_reg};
    assign rd_wide  = 64'(rd_pay_reg);
    assign rd_pay32 = rd_wide[31:0];
    assign load     = cmd.emit_sub | cmd.emit_mid | cmd.emit_final;

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            pay_reg <= payload;
            due_reg <= due_time;
            now_reg <= now_time;
        end
    end

    // Advance the scan index; the memory reads ahead at the next index
    always_comb
    begin
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // Set and clear slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write_slot)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
        else if (cmd.clear_slot)
        begin
            valid_reg[idx_reg] <= 1'b0;
        end
    end

    // Write and read the slot memory
    always_ff @(posedge clk)
    begin
        if (cmd.write_slot)
        begin
            mem_due[idx_reg] <= due_reg;
            mem_pay[idx_reg] <= wr_wide[PAYLOAD_BITS-1:0];
        end
        rd_due_reg <= mem_due[idx_next];
        rd_pay_reg <= mem_pay[idx_next];
    end

    // Keep the latest release until the next one or the end of the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (cmd.hold_load)
        begin
            held_valid_reg <= 1'b1;
        end
        else if (cmd.held_clr)
        begin
            held_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_load)
        begin
            held_pay_reg <= rd_pay32;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sub)
        begin
            kind_reg    <= KIND_SUBMIT;
            acc_reg     <= cmd.sub_acc;
            has_reg     <= 1'b0;
            pay_out_reg <= 32'd0;
            last_reg    <= 1'b1;
        end
        else if (cmd.emit_mid)
        begin
            kind_reg    <= KIND_POLL;
            acc_reg     <= 1'b0;
            has_reg     <= 1'b1;
            pay_out_reg <= held_pay_reg;
            last_reg    <= 1'b0;
        end
        else if (cmd.emit_final)
        begin
            kind_reg    <= KIND_POLL;
            acc_reg     <= 1'b0;
            has_reg     <= held_valid_reg;
            pay_out_reg <= held_valid_reg ? held_pay_reg : 32'd0;
            last_reg    <= 1'b1;
        end
    end

    // Status toward the controller
    always_comb
    begin
        sts.slot_free  = !valid_reg[idx_reg];
        sts.slot_hit   = valid_reg[idx_reg] && (rd_due_reg <= now_reg) && (op_reg == OP_POLL);
        sts.idx_last   = (idx_reg == IW'(SLOTS - 1));
        sts.held_valid = held_valid_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign accepted         = acc_reg;
    assign has_message      = has_reg;
    assign released_payload = pay_out_reg;
    assign last             = last_reg;

    // a new result never replaces one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load && out_valid_reg |-> out_ready)
        else $error("result loaded over a waiting item");

    // a submit only writes a free slot
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_slot |-> !valid_reg[idx_reg] && cmd.sub_acc)
        else $error("submit wrote an occupied slot");

    // a release only frees a slot that holds a due message
    a_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_slot |-> valid_reg[idx_reg] && (rd_due_reg <= now_reg))
        else $error("released a slot that is empty or not due");

    // a freed slot reads as empty on the following cycle
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_slot |=> !valid_reg[$past(idx_reg)])
        else $error("released slot still marked valid");

endmodule

`default_nettype wire

// ===== rtl/core/timed_message_release_table_core.sv =====
// Top level of the timed message release table: controller plus datapath.
//
// Input channel (in_valid/in_ready): op selects submit (store payload and
// due_time in the lowest free slot) or poll (release every stored message
// whose due time is at most now_time, in slot order, freeing its slot).
// Output channel (out_valid/out_ready): a submit gives one item with
// accepted set when a slot took it; a poll gives one item per released
// message with has_message set, or a single empty item, and marks the
// final one with last.
// Timing: one item is taken at a time; in_ready is high only while idle.
// A submit scans the slot valid bits one slot per cycle and loads its
// answer at the first free slot or after the last slot; the next item
// can be taken once the controller is back in idle. A poll walks every
// slot through the single read port of the slot memory, one slot per
// cycle while no second release waits on a busy output register, and
// loads its final result after the last slot.
// A finished result waits in an output register while the next item is
// taken. Stalls on out_ready hold the scan in place; nothing is dropped.
// Reset clears every slot valid bit at once, so the table starts empty.
`default_nettype none

module timed_message_release_table_core #(
    parameter int SLOTS        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [31:0] payload,
    input  wire logic [31:0] due_time,
    input  wire logic [31:0] now_time,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic             accepted,
    output logic             has_message,
    output logic [31:0]      released_payload,
    output logic             last
);
    import tmrt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tmrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    tmrt_datapath #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .op               (op),
        .payload          (payload),
        .due_time         (due_time),
        .now_time         (now_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .accepted         (accepted),
        .has_message      (has_message),
        .released_payload (released_payload),
        .last             (last)
    );

endmodule

`default_nettype wire
